// ===== sv/vmfr_pkg.sv =====
// Package for the display mode table and frame rate search block.
// Holds table sizes, field widths, divider request and status types and the
// lowest-set-bit encoder. No dependencies.
package vmfr_pkg;

  // Table geometry.
  localparam int MODE_SLOTS   = 128;
  localparam int TIMING_WORDS = 6;
  localparam int ENTRY_W      = $clog2(MODE_SLOTS);
  localparam int CNT_W        = $clog2(MODE_SLOTS + 1);
  localparam int TADDR_W      = $clog2(MODE_SLOTS * TIMING_WORDS);

  // Field widths.
  localparam int RES_W    = 12;
  localparam int TIM_W    = 12;
  localparam int PIX_W    = 18;
  localparam int SYNC_W   = 2;
  localparam int RATE_W   = 18;
  localparam int WANT_W   = 11;
  localparam int COLOR_W  = 24;
  localparam int DEPTH_W  = 5;
  localparam int WORD_W   = 18;
  localparam int SEL_W    = 4;
  localparam int MCOUNT_W = 8;

  // Arithmetic widths: sums of six timing words, their product, and the
  // rounded quotient numerator (2*P*1000 + H*V) over divisor 2*H*V.
  localparam int SUM_W     = 15;
  localparam int DEN_W     = 2 * SUM_W;
  localparam int SCALE_W   = 11;
  localparam int PIXX_W    = PIX_W + SCALE_W;
  localparam int NUM_W     = DEN_W + 1;
  localparam int DCNT_W    = $clog2(NUM_W + 1);
  localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(2000);
  localparam logic [RATE_W-1:0]  RATE_MAX   = {RATE_W{1'b1}};

  // Word select codes of a load beat.
  localparam logic [SEL_W-1:0] SEL_XRES    = SEL_W'(0);
  localparam logic [SEL_W-1:0] SEL_YRES    = SEL_W'(1);
  localparam logic [SEL_W-1:0] SEL_PIX     = SEL_W'(2);
  localparam logic [SEL_W-1:0] SEL_H_FIRST = SEL_W'(3);
  localparam logic [SEL_W-1:0] SEL_H_LAST  = SEL_W'(8);
  localparam logic [SEL_W-1:0] SEL_V_FIRST = SEL_W'(9);
  localparam logic [SEL_W-1:0] SEL_V_LAST  = SEL_W'(14);

  // Action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Divider request and status.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // One-based position of the lowest set bit, zero when no bit is set.
  function automatic logic [DEPTH_W-1:0] lowest_bit_pos(input logic [COLOR_W-1:0] v);
    logic [DEPTH_W-1:0] pos;
    pos = '0;
    for (int i = COLOR_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = DEPTH_W'(i + 1);
      end
    end
    return pos;
  endfunction

endpackage

// ===== sv/vmfr_cmd_if.sv =====
// Command channel: load and query beats into the mode table block.
// Depends on vmfr_pkg for field widths.
interface vmfr_cmd_if;
  import vmfr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [ENTRY_W-1:0]        entry_index;
  logic [SEL_W-1:0]          word_select;
  logic [WORD_W-1:0]         word_value;
  logic [RES_W-1:0]          want_width;
  logic [RES_W-1:0]          want_height;
  logic [COLOR_W-1:0]        colour_count;
  logic signed [WANT_W-1:0]  want_rate;

  modport source (
    output valid, action, entry_index, word_select, word_value,
           want_width, want_height, colour_count, want_rate,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, word_select, word_value,
           want_width, want_height, colour_count, want_rate,
    output ready
  );
endinterface

// ===== sv/vmfr_res_if.sv =====
// Result channel: one beat per command beat out of the mode table block.
// Depends on vmfr_pkg for field widths.
interface vmfr_res_if;
  import vmfr_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [ENTRY_W-1:0]  selected_entry;
  logic [RATE_W-1:0]   frame_rate;
  logic [DEPTH_W-1:0]  depth_code;
  logic [SYNC_W-1:0]   sync_polarity;
  logic                load_ack;

  modport source (
    output valid, found, selected_entry, frame_rate, depth_code,
           sync_polarity, load_ack,
    input  ready
  );

  modport sink (
    input  valid, found, selected_entry, frame_rate, depth_code,
           sync_polarity, load_ack,
    output ready
  );
endinterface

// ===== sv/vmfr_cfg_if.sv =====
// Configuration write channel carrying the mode count register value.
// Depends on vmfr_pkg for the register width.
interface vmfr_cfg_if;
  import vmfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [MCOUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/vmfr_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on vmfr_pkg for widths and the request and status structs.
module vmfr_div
  import vmfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DCNT_W-1:0] cnt;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [NUM_W-1:0]  den;
  logic [NUM_W:0]    rem_sh;
  logic [NUM_W:0]    diff;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff   = rem_sh - {1'b0, den};
  end

  // Iteration counter and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= DCNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end

    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (cnt != '0) begin
      if (!diff[NUM_W]) begin
        rem <= diff[NUM_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[NUM_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = (cnt != '0);
  assign rsp.quo  = quo;

endmodule

// ===== sv/video_mode_frame_rate_select.sv =====
// Display mode table with a frame rate search, top level.
// Depends on vmfr_pkg, the vmfr_cmd_if, vmfr_res_if and vmfr_cfg_if interfaces and vmfr_div.
//
// Usage: the cfg channel writes mode_count, the number of table entries a
// query searches (always ready; write it only while the block is idle).
// The cmd channel takes load beats, which write one word of one table entry,
// and query beats, which search the table for a resolution. Every cmd beat
// gives exactly one beat on the res channel.
// A load is answered in the cycle after it is accepted. A query visits the
// searched entries one by one under a small sequencer: an entry whose
// resolution does not match passes only the fetch, sum and next states; a
// matching one also sums its six timing memory reads, multiplies and runs the
// shared divider (skipped for a zero product); cmd is not ready meanwhile.
// The result sits in an output register: while it waits for res.ready the
// block takes no new beat, as a load or a query is taken only when the
// output register is free or being emptied in the same cycle.
// Reset clears mode_count and all control state. The table contents are
// not cleared and must be loaded before they are searched.
module video_mode_frame_rate_select
  import vmfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  vmfr_cfg_if.sink   cfg,
  vmfr_cmd_if.sink   cmd,
  vmfr_res_if.source res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_SUM,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_CMP,
    S_NEXT,
    S_DONE
  } state_t;

  // Table memories.
  logic [RES_W-1:0]  xres_mem [MODE_SLOTS];
  logic [RES_W-1:0]  yres_mem [MODE_SLOTS];
  logic [PIX_W-1:0]  pix_mem  [MODE_SLOTS];
  logic [SYNC_W-1:0] sync_mem [MODE_SLOTS];
  logic [TIM_W-1:0]  h_mem    [MODE_SLOTS * TIMING_WORDS];
  logic [TIM_W-1:0]  v_mem    [MODE_SLOTS * TIMING_WORDS];

  state_t              state;
  logic [MCOUNT_W-1:0] mode_count;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    e;
  logic [TADDR_W-1:0]  tbase;
  logic [2:0]          kcnt;

  // Query fields held for the whole search.
  logic [RES_W-1:0]  q_width;
  logic [RES_W-1:0]  q_height;
  logic [DEPTH_W-1:0] q_depth;
  logic              q_none;
  logic [WANT_W-1:0] q_rate;

  // Read data of the table.
  logic [RES_W-1:0]  xres_rd;
  logic [RES_W-1:0]  yres_rd;
  logic [PIX_W-1:0]  pix_rd;
  logic [SYNC_W-1:0] sync_rd;
  logic [TIM_W-1:0]  h_rd;
  logic [TIM_W-1:0]  v_rd;

  // Per-entry arithmetic.
  logic [SUM_W-1:0]  hsum;
  logic [SUM_W-1:0]  vsum;
  logic [DEN_W-1:0]  den_r;
  logic [PIXX_W-1:0] pixx_r;
  logic [RATE_W-1:0] cur_rate;

  // Search bookkeeping.
  logic               have_best;
  logic [ENTRY_W-1:0] best_pos;
  logic [RATE_W-1:0]  best_rate;
  logic [SYNC_W-1:0]  best_sync;
  logic               have_match;
  logic [ENTRY_W-1:0] match_pos;
  logic [RATE_W-1:0]  match_rate;
  logic [SYNC_W-1:0]  match_sync;

  logic               out_valid;
  logic               out_free;
  logic               cmd_fire;
  logic               load_ok;
  logic [TADDR_W-1:0] load_base;
  logic [TADDR_W-1:0] load_taddr;
  logic [TADDR_W-1:0] rd_taddr;
  logic               t_re;
  logic [CNT_W-1:0]   count_clip;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Handshake and address decode.
  always_comb begin
    out_free   = !out_valid || res.ready;
    cmd_fire   = cmd.valid && cmd.ready;
    load_ok    = ({{(TADDR_W-ENTRY_W){1'b0}}, cmd.entry_index} < TADDR_W'(MODE_SLOTS));
    load_base  = TADDR_W'({cmd.entry_index, 2'b00}) + TADDR_W'({cmd.entry_index, 1'b0});
    if (cmd.word_select <= SEL_H_LAST) begin
      load_taddr = load_base + TADDR_W'(cmd.word_select - SEL_H_FIRST);
    end else begin
      load_taddr = load_base + TADDR_W'(cmd.word_select - SEL_V_FIRST);
    end
    rd_taddr   = tbase + TADDR_W'(kcnt);
    t_re       = (state == S_SUM) && (kcnt != 3'(TIMING_WORDS));
    if ({{(CNT_W > MCOUNT_W ? CNT_W - MCOUNT_W : 0){1'b0}}, mode_count} > MCOUNT_W'(MODE_SLOTS)) begin
      count_clip = CNT_W'(MODE_SLOTS);
    end else begin
      count_clip = CNT_W'(mode_count);
    end
  end

  assign cmd.ready = (state == S_IDLE) && out_free;
  assign cfg.ready = 1'b1;

  // Entry-wide memories: load writes, reads at the current search entry.
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.action == ACT_LOAD && load_ok) begin
      case (cmd.word_select)
        SEL_XRES: xres_mem[cmd.entry_index] <= cmd.word_value[RES_W-1:0];
        SEL_YRES: yres_mem[cmd.entry_index] <= cmd.word_value[RES_W-1:0];
        SEL_PIX:  pix_mem[cmd.entry_index]  <= cmd.word_value[PIX_W-1:0];
        default: begin
          if (cmd.word_select > SEL_V_LAST) begin
            sync_mem[cmd.entry_index] <= cmd.word_value[SYNC_W-1:0];
          end
        end
      endcase
    end
    xres_rd <= xres_mem[e[ENTRY_W-1:0]];
    yres_rd <= yres_mem[e[ENTRY_W-1:0]];
    pix_rd  <= pix_mem[e[ENTRY_W-1:0]];
    sync_rd <= sync_mem[e[ENTRY_W-1:0]];
  end

  // Horizontal timing memory.
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.action == ACT_LOAD && load_ok &&
        cmd.word_select >= SEL_H_FIRST && cmd.word_select <= SEL_H_LAST) begin
      h_mem[load_taddr] <= cmd.word_value[TIM_W-1:0];
    end
    if (t_re) begin
      h_rd <= h_mem[rd_taddr];
    end
  end

  // Vertical timing memory.
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.action == ACT_LOAD && load_ok &&
        cmd.word_select >= SEL_V_FIRST && cmd.word_select <= SEL_V_LAST) begin
      v_mem[load_taddr] <= cmd.word_value[TIM_W-1:0];
    end
    if (t_re) begin
      v_rd <= v_mem[rd_taddr];
    end
  end

  // Divider request: rounded quotient of (2*P*1000 + H*V) / (2*H*V).
  always_comb begin
    div_req.start = (state == S_DIVGO) && (den_r != '0);
    div_req.num   = NUM_W'(pixx_r) + NUM_W'(den_r);
    div_req.den   = {den_r, 1'b0};
  end

  vmfr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer with the search registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      mode_count <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        mode_count <= cfg.data;
      end
      if (res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.action == ACT_LOAD) begin
              out_valid          <= 1'b1;
              res.found          <= 1'b0;
              res.selected_entry <= '0;
              res.frame_rate     <= '0;
              res.depth_code     <= '0;
              res.sync_polarity  <= '0;
              res.load_ack       <= 1'b1;
            end else begin
              q_width    <= cmd.want_width;
              q_height   <= cmd.want_height;
              q_depth    <= lowest_bit_pos(cmd.colour_count);
              q_none     <= cmd.want_rate[WANT_W-1];
              q_rate     <= cmd.want_rate;
              limit      <= count_clip;
              e          <= '0;
              tbase      <= '0;
              have_best  <= 1'b0;
              have_match <= 1'b0;
              state      <= (count_clip == '0) ? S_DONE : S_FETCH;
            end
          end
        end

        S_FETCH: begin
          kcnt  <= '0;
          hsum  <= '0;
          vsum  <= '0;
          state <= S_SUM;
        end

        S_SUM: begin
          if (kcnt == '0 && (xres_rd != q_width || yres_rd != q_height)) begin
            state <= S_NEXT;
          end else begin
            if (kcnt != '0) begin
              hsum <= hsum + SUM_W'(h_rd);
              vsum <= vsum + SUM_W'(v_rd);
            end
            if (kcnt == 3'(TIMING_WORDS)) begin
              state <= S_MUL;
            end else begin
              kcnt <= kcnt + 1'b1;
            end
          end
        end

        S_MUL: begin
          den_r  <= hsum * vsum;
          pixx_r <= pix_rd * RATE_SCALE;
          state  <= S_DIVGO;
        end

        S_DIVGO: begin
          if (den_r == '0) begin
            cur_rate <= '0;
            state    <= S_CMP;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (!div_rsp.busy) begin
            if (div_rsp.quo > NUM_W'(RATE_MAX)) begin
              cur_rate <= RATE_MAX;
            end else begin
              cur_rate <= div_rsp.quo[RATE_W-1:0];
            end
            state <= S_CMP;
          end
        end

        S_CMP: begin
          if (!have_best || cur_rate > best_rate) begin
            have_best <= 1'b1;
            best_rate <= cur_rate;
            best_pos  <= e[ENTRY_W-1:0];
            best_sync <= sync_rd;
          end
          if (!q_none && cur_rate == RATE_W'(q_rate)) begin
            have_match <= 1'b1;
            match_rate <= cur_rate;
            match_pos  <= e[ENTRY_W-1:0];
            match_sync <= sync_rd;
          end
          state <= S_NEXT;
        end

        S_NEXT: begin
          e     <= e + 1'b1;
          tbase <= tbase + TADDR_W'(TIMING_WORDS);
          state <= (e + 1'b1 == limit) ? S_DONE : S_FETCH;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            res.load_ack <= 1'b0;
            res.found    <= have_best;
            if (!have_best) begin
              res.selected_entry <= '0;
              res.frame_rate     <= '0;
              res.depth_code     <= '0;
              res.sync_polarity  <= '0;
            end else if (have_match) begin
              res.selected_entry <= match_pos;
              res.frame_rate     <= match_rate;
              res.depth_code     <= q_depth;
              res.sync_polarity  <= match_sync;
            end else begin
              res.selected_entry <= best_pos;
              res.frame_rate     <= best_rate;
              res.depth_code     <= q_depth;
              res.sync_polarity  <= best_sync;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = out_valid;

  // A found result is never a load acknowledge.
  a_found_not_load: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.found |-> !res.load_ack)
    else $error("found result flagged as load acknowledge");

  // A result that found nothing carries no entry and no rate.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.found |-> res.selected_entry == '0 && res.frame_rate == '0)
    else $error("not-found result carries entry or rate");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // An accepted query keeps the command side closed on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.action == ACT_QUERY |=> !cmd.ready)
    else $error("command accepted during a query");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for video_mode_frame_rate_select: loads a display mode table,
// runs directed and random queries, and checks every result beat against a local predictor.
// Depends on vmfr_pkg and the vmfr_cmd_if, vmfr_res_if and vmfr_cfg_if interfaces.
module tb;
  import vmfr_pkg::*;

  localparam int PERIOD      = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TIM_MAX     = (1 << TIM_W) - 1;
  localparam logic [SEL_W-1:0] SEL_SYNC = SEL_W'(15);

  // One command beat and one result beat, as the predictor sees them.
  typedef struct packed {
    logic                     action;
    logic [ENTRY_W-1:0]       entry_index;
    logic [SEL_W-1:0]         word_select;
    logic [WORD_W-1:0]        word_value;
    logic [RES_W-1:0]         want_width;
    logic [RES_W-1:0]         want_height;
    logic [COLOR_W-1:0]       colour_count;
    logic signed [WANT_W-1:0] want_rate;
  } mode_cmd_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] selected_entry;
    logic [RATE_W-1:0]  frame_rate;
    logic [DEPTH_W-1:0] depth_code;
    logic [SYNC_W-1:0]  sync_polarity;
    logic               load_ack;
  } mode_res_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

  logic clk;
  logic rst;

  vmfr_cmd_if cmd_ch ();
  vmfr_res_if res_ch ();
  vmfr_cfg_if cfg_ch ();

  video_mode_frame_rate_select u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Predictor copy of the mode table and of the mode count register.
  logic [RES_W-1:0]  tab_xres [MODE_SLOTS];
  logic [RES_W-1:0]  tab_yres [MODE_SLOTS];
  logic [PIX_W-1:0]  tab_pix  [MODE_SLOTS];
  logic [TIM_W-1:0]  tab_h    [MODE_SLOTS][TIMING_WORDS];
  logic [TIM_W-1:0]  tab_v    [MODE_SLOTS][TIMING_WORDS];
  logic [SYNC_W-1:0] tab_sync [MODE_SLOTS];
  logic [MCOUNT_W-1:0] searched_count;

  mode_cmd_t cmd_backlog[$];
  mode_res_t predicted_results[$];

  bit          cmd_taken;
  int          burst_left;
  int          gap_left;
  int          res_hold;
  int          rx_cycle;
  rx_pattern_e rx_pattern;
  int          cycle_count;
  int          mismatch_count;

  always #(PERIOD / 2) clk = ~clk;

  // Rounded frame rate of one table entry, saturated to the result width.
  function automatic logic [RATE_W-1:0] mode_frame_rate(int e);
    longint unsigned hsum, vsum, den, quo;
    hsum = 0;
    vsum = 0;
    for (int k = 0; k < TIMING_WORDS; k++) begin
      hsum += tab_h[e][k];
      vsum += tab_v[e][k];
    end
    den = hsum * vsum;
    if (den == 0) begin
      return '0;
    end
    quo = (64'(tab_pix[e]) * 64'd2000 + den) / (64'd2 * den);
    if (quo > 64'(RATE_MAX)) begin
      return RATE_MAX;
    end
    return quo[RATE_W-1:0];
  endfunction

  // One-based position of the lowest set colour bit.
  function automatic logic [DEPTH_W-1:0] colour_depth(logic [COLOR_W-1:0] v);
    for (int i = 0; i < COLOR_W; i++) begin
      if (v[i]) begin
        return DEPTH_W'(i + 1);
      end
    end
    return '0;
  endfunction

  // A load writes one word of one entry, truncated to the word's width.
  function automatic void store_word(mode_cmd_t c);
    if (c.word_select == SEL_XRES) begin
      tab_xres[c.entry_index] = c.word_value[RES_W-1:0];
    end else if (c.word_select == SEL_YRES) begin
      tab_yres[c.entry_index] = c.word_value[RES_W-1:0];
    end else if (c.word_select == SEL_PIX) begin
      tab_pix[c.entry_index] = c.word_value[PIX_W-1:0];
    end else if (c.word_select <= SEL_H_LAST) begin
      tab_h[c.entry_index][c.word_select - SEL_H_FIRST] = c.word_value[TIM_W-1:0];
    end else if (c.word_select <= SEL_V_LAST) begin
      tab_v[c.entry_index][c.word_select - SEL_V_FIRST] = c.word_value[TIM_W-1:0];
    end else begin
      tab_sync[c.entry_index] = c.word_value[SYNC_W-1:0];
    end
  endfunction

  // Query: last exact rate match among matching entries, else first highest rate.
  function automatic mode_res_t search_modes(mode_cmd_t c);
    mode_res_t         r;
    int                limit;
    int                best;
    int                hit;
    bit                have_best;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] best_rate;
    r = '0;
    limit = (searched_count > MODE_SLOTS) ? MODE_SLOTS : searched_count;
    best = 0;
    hit = -1;
    have_best = 1'b0;
    best_rate = '0;
    for (int e = 0; e < limit; e++) begin
      if (tab_xres[e] == c.want_width && tab_yres[e] == c.want_height) begin
        rate = mode_frame_rate(e);
        if (!have_best || rate > best_rate) begin
          have_best = 1'b1;
          best_rate = rate;
          best = e;
        end
        if (c.want_rate >= 0 && int'(rate) == int'(c.want_rate)) begin
          hit = e;
        end
      end
    end
    if (hit >= 0) begin
      best = hit;
    end
    if (have_best) begin
      r.found = 1'b1;
      r.selected_entry = ENTRY_W'(best);
      r.frame_rate = mode_frame_rate(best);
      r.depth_code = colour_depth(c.colour_count);
      r.sync_polarity = tab_sync[best];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // A few common resolutions, so that random entries share them.
  task automatic palette_res(int i, output logic [RES_W-1:0] x, output logic [RES_W-1:0] y);
    case (i)
      0: begin x = 640;  y = 480;  end
      1: begin x = 800;  y = 600;  end
      2: begin x = 1024; y = 768;  end
      default: begin x = 1280; y = 1024; end
    endcase
  endtask

  // Queue a load beat; unused query fields and the bits above the word's width are noise.
  task automatic push_load(int e, logic [SEL_W-1:0] sel, logic [WORD_W-1:0] value);
    mode_cmd_t c;
    c = mode_cmd_t'({$urandom, $urandom, $urandom});
    c.action = ACT_LOAD;
    c.entry_index = ENTRY_W'(e);
    c.word_select = sel;
    c.word_value = value;
    if (sel == SEL_SYNC) begin
      c.word_value[WORD_W-1:SYNC_W] = $urandom;
    end else if (sel != SEL_PIX) begin
      c.word_value[WORD_W-1:RES_W] = $urandom;
    end
    cmd_backlog.push_back(c);
  endtask

  task automatic push_query(logic [RES_W-1:0] w, logic [RES_W-1:0] h,
                            logic [COLOR_W-1:0] colours, int want);
    mode_cmd_t c;
    c = mode_cmd_t'({$urandom, $urandom, $urandom});
    c.action = ACT_QUERY;
    c.want_width = w;
    c.want_height = h;
    c.colour_count = colours;
    c.want_rate = WANT_W'(want);
    cmd_backlog.push_back(c);
  endtask

  // Split a timing total over the six words of one group, each word in range.
  task automatic push_spread(int e, logic [SEL_W-1:0] first, int total);
    int left, lo, hi, part;
    left = total;
    for (int k = 0; k < TIMING_WORDS; k++) begin
      hi = (left < TIM_MAX) ? left : TIM_MAX;
      lo = left - TIM_MAX * (TIMING_WORDS - 1 - k);
      if (lo < 0) begin
        lo = 0;
      end
      part = $urandom_range(hi, lo);
      left -= part;
      push_load(e, first + SEL_W'(k), WORD_W'(part));
    end
  endtask

  task automatic load_mode(int e, logic [RES_W-1:0] x, logic [RES_W-1:0] y,
                           logic [PIX_W-1:0] pix, int hsum, int vsum, logic [SYNC_W-1:0] sync);
    push_load(e, SEL_XRES, WORD_W'(x));
    push_load(e, SEL_YRES, WORD_W'(y));
    push_load(e, SEL_PIX, pix);
    push_spread(e, SEL_H_FIRST, hsum);
    push_spread(e, SEL_V_FIRST, vsum);
    push_load(e, SEL_SYNC, WORD_W'(sync));
  endtask

  // Random query, mostly for a resolution present among the searched entries.
  task automatic random_query(int searched);
    int                 pick, e, want;
    logic [RES_W-1:0]   x, y;
    logic [COLOR_W-1:0] colours;
    pick = $urandom_range(0, 9);
    e = -1;
    if (pick < 7 && searched > 0) begin
      e = $urandom_range(0, searched - 1);
      x = tab_xres[e];
      y = tab_yres[e];
    end else if (pick < 9) begin
      palette_res($urandom_range(0, 3), x, y);
    end else begin
      x = $urandom;
      y = $urandom;
    end
    pick = $urandom_range(0, 9);
    if (pick < 4 && e >= 0 && mode_frame_rate(e) <= 1023) begin
      want = mode_frame_rate(e);
    end else if (pick < 6) begin
      want = -1;
    end else if (pick == 6) begin
      want = -int'($urandom_range(1, 1024));
    end else begin
      want = $urandom_range(0, 1023);
    end
    colours = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      colours = colours << $urandom_range(0, COLOR_W - 1);
    end
    if ($urandom_range(0, 9) == 0) begin
      colours = '0;
    end
    push_query(x, y, colours, want);
  endtask

  // Random load, mostly into the searched entries with plausible contents.
  task automatic random_load(int searched);
    int                e;
    logic [SEL_W-1:0]  sel;
    logic [RES_W-1:0]  x, y;
    logic [WORD_W-1:0] v;
    if (searched > 0 && $urandom_range(0, 3) != 0) begin
      e = $urandom_range(0, searched - 1);
    end else begin
      e = $urandom_range(0, MODE_SLOTS - 1);
    end
    sel = $urandom;
    palette_res($urandom_range(0, 3), x, y);
    v = $urandom;
    if (sel == SEL_XRES) begin
      v[RES_W-1:0] = x;
    end else if (sel == SEL_YRES) begin
      v[RES_W-1:0] = y;
    end else if (sel >= SEL_H_FIRST && sel <= SEL_V_LAST && $urandom_range(0, 4) != 0) begin
      v[RES_W-1:0] = $urandom_range(0, 500);
    end
    push_load(e, sel, v);
  endtask

  // Wait until every queued beat is taken and every predicted result has arrived.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode_count(logic [MCOUNT_W-1:0] count);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= count;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    searched_count = count;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Command driver: offers the head of the backlog in bursts with random gaps.
  always @(negedge clk) begin
    mode_cmd_t c;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog[0];
        cmd_ch.valid <= 1'b1;
        cmd_ch.action <= c.action;
        cmd_ch.entry_index <= c.entry_index;
        cmd_ch.word_select <= c.word_select;
        cmd_ch.word_value <= c.word_value;
        cmd_ch.want_width <= c.want_width;
        cmd_ch.want_height <= c.want_height;
        cmd_ch.colour_count <= c.colour_count;
        cmd_ch.want_rate <= c.want_rate;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Predictor: each accepted command beat updates the table or yields a search result.
  always @(posedge clk) begin
    mode_cmd_t c;
    mode_res_t r;
    cmd_taken = 1'b0;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c = cmd_backlog.pop_front();
      cmd_taken = 1'b1;
      if (c.action == ACT_LOAD) begin
        store_word(c);
        r = '0;
        r.load_ack = 1'b1;
      end else begin
        r = search_modes(c);
      end
      predicted_results.push_back(r);
    end
  end

  // Result receiver: a long hold-off on request, otherwise a changing stall pattern.
  always @(negedge clk) begin
    if (res_hold != 0) begin
      res_hold--;
      res_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 160 == 0) begin
        rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      end
      case (rx_pattern)
        RX_OPEN:   res_ch.ready <= 1'b1;
        RX_COIN:   res_ch.ready <= $urandom_range(0, 1);
        RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   res_ch.ready <= (rx_cycle % 9) >= 4;
      endcase
    end
  end

  // Result checker: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    mode_res_t r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatch_count++;
      end else begin
        r = predicted_results.pop_front();
        check_field("found", r.found, res_ch.found);
        check_field("selected_entry", r.selected_entry, res_ch.selected_entry);
        check_field("frame_rate", r.frame_rate, res_ch.frame_rate);
        check_field("depth_code", r.depth_code, res_ch.depth_code);
        check_field("sync_polarity", r.sync_polarity, res_ch.sync_polarity);
        check_field("load_ack", r.load_ack, res_ch.load_ack);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [RES_W-1:0] x, y;
    int               hsum, count, n, searched;
    clk = 1'b0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_LOAD;
    cmd_ch.entry_index = '0;
    cmd_ch.word_select = '0;
    cmd_ch.word_value = '0;
    cmd_ch.want_width = '0;
    cmd_ch.want_height = '0;
    cmd_ch.colour_count = '0;
    cmd_ch.want_rate = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    searched_count = '0;
    rx_pattern = RX_OPEN;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table so no search ever reads an unwritten entry.
    // Entries 0 to 7 hold the hand-made cases: a tie of equal rates, a higher rate,
    // a zero total, saturated rates that tie, the largest timings, and an exact half.
    load_mode(0, 800, 600, 40000, 1056, 628, 1);
    load_mode(1, 800, 600, 40000, 1056, 628, 2);
    load_mode(2, 800, 600, 80000, 1056, 628, 3);
    load_mode(3, 4095, 4095, 262143, 0, 750, 0);
    load_mode(4, 1, 1, 262143, 1, 1, 1);
    load_mode(5, 1, 1, 200000, 6, 6, 2);
    load_mode(6, 0, 0, 262143, TIMING_WORDS * TIM_MAX, TIMING_WORDS * TIM_MAX, 3);
    load_mode(7, 800, 600, 121, 1, 2000, 2);
    for (int e = 8; e < MODE_SLOTS; e++) begin
      palette_res($urandom_range(0, 3), x, y);
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom;
        y = $urandom;
      end
      hsum = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(300, 2600);
      load_mode(e, x, y, $urandom, hsum, $urandom_range(200, 1600), $urandom);
    end
    wait_idle();

    // Directed queries over the hand-made entries.
    write_mode_count(8);
    push_query(800, 600, 0, -1);
    push_query(800, 600, 24'hFFFFFF, mode_frame_rate(0));
    push_query(800, 600, 24'h800000, mode_frame_rate(7));
    push_query(4095, 4095, 1, 0);
    push_query(4095, 4095, $urandom, -1024);
    push_query(1, 1, $urandom, -1);
    push_query(1, 1, $urandom, 1023);
    push_query(0, 0, $urandom, 0);
    push_query(12'hABC, 12'h123, $urandom, 60);
    wait_idle();
    write_mode_count(0);
    push_query(800, 600, $urandom, -1);
    wait_idle();
    write_mode_count(255);
    push_query(800, 600, $urandom, -1);
    push_query(640, 480, $urandom, mode_frame_rate(1));
    wait_idle();
    write_mode_count(128);
    push_query(1024, 768, $urandom, 60);
    wait_idle();

    // Random rounds, each under its own mode count; one round holds off the receiver.
    for (int rnd = 0; rnd < 12; rnd++) begin
      n = $urandom_range(0, 9);
      if (n == 0) begin
        count = $urandom_range(128, 255);
      end else if (n == 1) begin
        count = $urandom_range(0, 2);
      end else begin
        count = $urandom_range(3, 24);
      end
      write_mode_count(count);
      searched = (count > MODE_SLOTS) ? MODE_SLOTS : count;
      if (rnd == 5) begin
        res_hold = 300;
        n = 24;
      end else begin
        n = $urandom_range(6, 14);
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < ((rnd == 5) ? 2 : 6)) begin
          random_query(searched);
        end else begin
          random_load(searched);
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
